[design/encoder_driven_stepper_pulser_defines.svh]
// Assertion macros shared by the stepper pulser modules.
// Needs a clock i_clk and a synchronous active-low reset i_rst_n in scope.
`ifndef ENCODER_DRIVEN_STEPPER_PULSER_DEFINES_SVH
`define ENCODER_DRIVEN_STEPPER_PULSER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define EDSP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define EDSP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/edsp_pkg.sv]
// Shared types and constants for the encoder driven stepper pulser.
// No dependencies; used by the controller, datapath, divider and top level.
`default_nettype none

package edsp_pkg;

    // Word widths on the stream ports
    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;

    // Field widths
    localparam int POS_W    = 16;
    localparam int SPEED_W  = 15;
    localparam int PERIOD_W = 20;
    localparam int SHIFT_W  = 3;
    localparam int MOD_W    = POS_W + 1;

    // Serial divider: one quotient bit a cycle
    localparam int DIV_STEPS = PERIOD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Command codes carried in tuser
    typedef enum logic [2:0] {
        OP_PIN    = 3'd0,
        OP_TICK   = 3'd1,
        OP_RUN_ON = 3'd2,
        OP_RUN_OFF = 3'd3,
        OP_ZERO   = 3'd4,
        OP_LOAD   = 3'd5
    } t_opcode;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROLLOVER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MSHIFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 3'd3;

    // Configuration reset values
    localparam logic [POS_W-1:0]    RST_ROLLOVER = 16'd100;
    localparam logic                RST_CRUISE   = 1'b1;
    localparam logic [SHIFT_W-1:0]  RST_MSHIFT   = 3'd1;
    localparam logic [PERIOD_W-1:0] RST_BASE     = 20'd300000;

    // Encoder decoding
    localparam logic [1:0]       DETENT  = 2'b11;
    localparam logic [POS_W-1:0] CCW_SIG = 16'h0102;
    localparam logic [POS_W-1:0] CW_SIG  = 16'h0201;
    localparam logic signed [POS_W-1:0] COUNT_LIMIT = 16'sd32767;
    localparam logic [PERIOD_W-1:0] ELAPSED_MAX = 20'hF_FFFF;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;      // capture the input word
        logic hist;       // shift a pin state into the history
        logic start_mod;  // start the wrap modulo
        logic take_mod;   // commit the wrapped position and click count
        logic click;      // finish a detent sample
        logic simple;     // apply a simple command
        logic pulse_set;  // step mode pulse
        logic run_stop;   // drop the run flag
        logic start_per;  // start the period division
        logic take_per;   // commit the new period
        logic out_load;   // load the result word
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_opcode op;
        logic    detent;
        logic    sig_match;
        logic    pos_changed;
        logic    cruise;
        logic    speed_zero;
        logic    div_done;
    } t_status;

endpackage

`default_nettype wire

[design/edsp_div.sv]
// Restoring serial divider giving quotient and remainder, one bit a cycle.
// Depends on edsp_pkg and the assertion macro header.
`default_nettype none

`include "encoder_driven_stepper_pulser_defines.svh"

module edsp_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [edsp_pkg::PERIOD_W-1:0] i_dividend,
    input  wire logic [edsp_pkg::MOD_W-1:0]    i_divisor,
    output logic                               o_done,
    output logic [edsp_pkg::PERIOD_W-1:0]      o_quotient,
    output logic [edsp_pkg::MOD_W-1:0]         o_remainder
);

    logic                              r_busy;
    logic                              r_done;
    logic [edsp_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [edsp_pkg::MOD_W-1:0]        r_rem;
    logic [edsp_pkg::MOD_W-1:0]        r_dsr;
    logic [edsp_pkg::PERIOD_W-1:0]     r_quo;

    logic [edsp_pkg::MOD_W:0]          w_trial;
    logic [edsp_pkg::MOD_W:0]          w_diff;
    logic                              w_ge;

    // Trial subtract of the shifted partial remainder
    assign w_trial = {r_rem, r_quo[edsp_pkg::PERIOD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dsr});
    assign w_diff  = w_trial - {1'b0, r_dsr};

    // Control: busy flag, step count and done strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == edsp_pkg::DIV_CNT_W'(edsp_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // Payload: shift the dividend through, build the quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[edsp_pkg::MOD_W-1:0] : w_trial[edsp_pkg::MOD_W-1:0];
            r_quo <= {r_quo[edsp_pkg::PERIOD_W-2:0], w_ge};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    `EDSP_ASSERT_IMP(a_no_restart, i_start, !r_busy, "divider started while busy")
    `EDSP_ASSERT_IMP(a_rem_below, r_done, r_rem < r_dsr, "remainder not below divisor")

endmodule

`default_nettype wire

[design/edsp_ctrl.sv]
// Sequencer for the stepper pulser: walks each command word through decode,
// divider passes and result hand-off. Depends on edsp_pkg and the macro header.
`default_nettype none

`include "encoder_driven_stepper_pulser_defines.svh"

module edsp_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    input  wire edsp_pkg::t_status i_status,
    output edsp_pkg::t_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MOD,
        S_CLICK,
        S_EVT,
        S_PER,
        S_OUT
    } t_state;

    t_state         r_state;
    t_state         n_state;
    logic           r_out_valid;
    edsp_pkg::t_cmd w_cmd;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    w_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_status.op)
                    edsp_pkg::OP_PIN: begin
                        if (!i_status.detent) begin
                            w_cmd.hist = 1'b1;
                            n_state    = S_OUT;
                        end else if (i_status.sig_match) begin
                            w_cmd.start_mod = 1'b1;
                            n_state         = S_MOD;
                        end else begin
                            n_state = S_CLICK;
                        end
                    end
                    edsp_pkg::OP_RUN_ON, edsp_pkg::OP_RUN_OFF: begin
                        w_cmd.simple = 1'b1;
                        n_state      = S_EVT;
                    end
                    default: begin
                        w_cmd.simple = 1'b1;
                        n_state      = S_OUT;
                    end
                endcase
            end
            S_MOD: begin
                if (i_status.div_done) begin
                    w_cmd.take_mod = 1'b1;
                    n_state        = S_CLICK;
                end
            end
            S_CLICK: begin
                w_cmd.click = 1'b1;
                n_state     = i_status.pos_changed ? S_EVT : S_OUT;
            end
            S_EVT: begin
                if (!i_status.cruise) begin
                    w_cmd.pulse_set = 1'b1;
                    n_state         = S_OUT;
                end else if (i_status.speed_zero) begin
                    w_cmd.run_stop = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    w_cmd.start_per = 1'b1;
                    n_state         = S_PER;
                end
            end
            S_PER: begin
                if (i_status.div_done) begin
                    w_cmd.take_per = 1'b1;
                    n_state        = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_cmd      = w_cmd;

    `EDSP_ASSERT_NXT(a_one_at_a_time, i_s_tvalid && o_s_tready, !o_s_tready,
        "second word accepted while one is in work")
    `EDSP_ASSERT_IMP(a_done_expected, i_status.div_done, r_state == S_MOD || r_state == S_PER,
        "divider finished outside a divide state")
    `EDSP_ASSERT_NXT(a_result_shown, w_cmd.out_load, o_m_tvalid,
        "result word loaded but not presented")

endmodule

`default_nettype wire

[design/edsp_dp.sv]
// Datapath of the stepper pulser: configuration, encoder state, timing and
// the result register. Depends on edsp_pkg and edsp_div.
`default_nettype none

module edsp_dp (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic [edsp_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  wire logic [edsp_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    input  wire logic                             i_cfg_valid,
    input  wire logic [edsp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [edsp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire edsp_pkg::t_cmd                   i_cmd,
    output edsp_pkg::t_status                     o_status,
    output logic [edsp_pkg::OUT_TDATA_W-1:0]      o_m_tdata
);

    // Configuration
    logic [edsp_pkg::POS_W-1:0]    r_rollover;
    logic                          r_cruise;
    logic [edsp_pkg::SHIFT_W-1:0]  r_mshift;
    logic [edsp_pkg::PERIOD_W-1:0] r_base;

    // Encoder and timing state
    logic [edsp_pkg::POS_W-1:0]        r_hist;
    logic [edsp_pkg::POS_W-1:0]        r_pos;
    logic signed [edsp_pkg::POS_W-1:0] r_count;
    logic [edsp_pkg::SPEED_W-1:0]      r_speed;
    logic                              r_dir;
    logic [edsp_pkg::PERIOD_W-1:0]     r_period;
    logic [edsp_pkg::PERIOD_W-1:0]     r_elapsed;
    logic                              r_run;
    logic                              r_mstop;

    // Word in work
    logic [edsp_pkg::IN_TUSER_W-1:0] r_op;
    logic [1:0]                      r_pins;
    logic [edsp_pkg::POS_W-1:0]      r_pos_val;
    logic [edsp_pkg::POS_W-1:0]      r_before;
    logic                            r_pulse;
    logic [edsp_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic                          w_ccw;
    logic                          w_cw;
    logic [edsp_pkg::MOD_W-1:0]    w_mod;
    logic [edsp_pkg::MOD_W-1:0]    w_mod_num;
    logic [edsp_pkg::POS_W-1:0]    w_abs;
    logic [edsp_pkg::PERIOD_W-1:0] w_el_inc;
    logic                          w_tick_pulse;
    logic [edsp_pkg::PERIOD_W-1:0] w_dividend;
    logic [edsp_pkg::MOD_W-1:0]    w_divisor;
    logic                          w_div_done;
    logic [edsp_pkg::PERIOD_W-1:0] w_quo;
    logic [edsp_pkg::MOD_W-1:0]    w_rem;
    logic                          w_cfg_cruise;

    // Click signatures and the wrap modulus (zero rollover means a full 16-bit wrap)
    assign w_ccw = (r_hist == edsp_pkg::CCW_SIG);
    assign w_cw  = (r_hist == edsp_pkg::CW_SIG);
    assign w_mod = (r_rollover == '0) ? {1'b1, {edsp_pkg::POS_W{1'b0}}}
                                      : {1'b0, r_rollover};
    assign w_mod_num = w_ccw ? ({1'b0, r_pos} + w_mod - 1'b1) : ({1'b0, r_pos} + 1'b1);

    // Speed magnitude from the signed click count
    assign w_abs = r_count[edsp_pkg::POS_W-1] ? ('0 - $unsigned(r_count)) : $unsigned(r_count);

    // Tick: saturating elapsed count and the fire test
    assign w_el_inc = (r_run && r_elapsed != edsp_pkg::ELAPSED_MAX) ? r_elapsed + 1'b1
                                                                    : r_elapsed;
    assign w_tick_pulse = r_cruise && r_run && (r_speed != '0) && (w_el_inc > r_period);

    // Shared divider: wrap modulo or base delay over speed
    assign w_dividend = i_cmd.start_per ? r_base
                                        : {{(edsp_pkg::PERIOD_W-edsp_pkg::MOD_W){1'b0}}, w_mod_num};
    assign w_divisor  = i_cmd.start_per ? {2'b00, r_speed} : w_mod;

    edsp_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.start_mod || i_cmd.start_per),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    assign w_cfg_cruise = i_cfg_data[0];

    // Configuration and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rollover <= edsp_pkg::RST_ROLLOVER;
            r_cruise   <= edsp_pkg::RST_CRUISE;
            r_mshift   <= edsp_pkg::RST_MSHIFT;
            r_base     <= edsp_pkg::RST_BASE;
            r_hist     <= '0;
            r_pos      <= '0;
            r_count    <= '0;
            r_speed    <= '0;
            r_dir      <= 1'b0;
            r_period   <= '0;
            r_elapsed  <= '0;
            r_run      <= 1'b1;
            r_mstop    <= 1'b0;
            r_pulse    <= 1'b0;
        end else begin
            // Register writes; a mode change zeroes the encoder under the new mode
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    edsp_pkg::CFG_ROLLOVER: r_rollover <= i_cfg_data[edsp_pkg::POS_W-1:0];
                    edsp_pkg::CFG_CRUISE: begin
                        if (w_cfg_cruise != r_cruise) begin
                            r_cruise <= w_cfg_cruise;
                            r_pos    <= '0;
                            r_count  <= '0;
                            r_speed  <= '0;
                            if (w_cfg_cruise) begin
                                r_run <= 1'b0;
                            end
                        end
                    end
                    edsp_pkg::CFG_MSHIFT: r_mshift <= i_cfg_data[edsp_pkg::SHIFT_W-1:0];
                    edsp_pkg::CFG_BASE:   r_base   <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_cmd.latch) begin
                r_pulse <= 1'b0;
            end

            // Away from detent: shift the pin state in
            if (i_cmd.hist) begin
                r_hist <= {r_hist[edsp_pkg::POS_W-5:0], 2'b00, r_pins};
            end

            // Commit a click: wrapped position, direction, saturating count
            if (i_cmd.take_mod) begin
                r_pos <= w_rem[edsp_pkg::POS_W-1:0];
                if (w_ccw) begin
                    r_dir <= 1'b1;
                    if (r_count > -edsp_pkg::COUNT_LIMIT) begin
                        r_count <= r_count - 16'sd1;
                    end
                end else begin
                    r_dir <= 1'b0;
                    if (r_count < edsp_pkg::COUNT_LIMIT) begin
                        r_count <= r_count + 16'sd1;
                    end
                end
            end

            // Finish a detent sample: cruise speed and direction, clear history
            if (i_cmd.click) begin
                r_hist <= '0;
                if (r_cruise) begin
                    r_speed <= w_abs[edsp_pkg::SPEED_W-1:0];
                    r_dir   <= r_count[edsp_pkg::POS_W-1];
                end
            end

            // Simple commands
            if (i_cmd.simple) begin
                case (edsp_pkg::t_opcode'(r_op))
                    edsp_pkg::OP_TICK: begin
                        if (w_tick_pulse) begin
                            r_pulse   <= 1'b1;
                            r_elapsed <= '0;
                        end else begin
                            r_elapsed <= w_el_inc;
                        end
                    end
                    edsp_pkg::OP_RUN_ON: begin
                        r_run   <= 1'b1;
                        r_mstop <= 1'b0;
                    end
                    edsp_pkg::OP_RUN_OFF: begin
                        r_run   <= 1'b0;
                        r_mstop <= 1'b1;
                    end
                    edsp_pkg::OP_ZERO: begin
                        r_pos   <= '0;
                        r_count <= '0;
                        r_speed <= '0;
                        if (r_cruise) begin
                            r_run <= 1'b0;
                        end
                    end
                    edsp_pkg::OP_LOAD: r_pos <= r_pos_val;
                    default: ;
                endcase
            end

            // Position change outcomes
            if (i_cmd.pulse_set) begin
                r_pulse <= 1'b1;
            end
            if (i_cmd.run_stop) begin
                r_run <= 1'b0;
            end
            if (i_cmd.take_per) begin
                r_period <= w_quo >> r_mshift;
                if (!r_mstop) begin
                    r_run <= 1'b1;
                end
            end
        end
    end

    // Input word capture and result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op      <= i_s_tuser;
            r_pins    <= i_s_tdata[1:0];
            r_pos_val <= i_s_tdata[edsp_pkg::POS_W+1:2];
            r_before  <= r_pos;
        end
        if (i_cmd.out_load) begin
            r_out_data <= {2'b00, r_run, r_period, r_speed, r_pos, r_dir, r_pulse};
        end
    end

    always_comb begin
        o_status.op          = edsp_pkg::t_opcode'(r_op);
        o_status.detent      = (r_pins == edsp_pkg::DETENT);
        o_status.sig_match   = w_ccw || w_cw;
        o_status.pos_changed = (r_pos != r_before);
        o_status.cruise      = r_cruise;
        o_status.speed_zero  = (r_speed == '0);
        o_status.div_done    = w_div_done;
    end

    assign o_m_tdata = r_out_data;

endmodule

`default_nettype wire

[design/encoder_driven_stepper_pulser.sv]
// Encoder driven stepper pulser: each input word is a pin sample, a microsecond
// tick or a command, and yields one result word with step pulse, direction,
// position, speed, period and run flag. Words are handled one at a time. Tick,
// zero, load, unused opcodes and off-detent samples go from decode straight to
// the result hand-off; run on and off pass the event step first, and detent
// samples without a click the click step. A detent sample with a click runs the
// 20-step serial divider for the wrap modulo and, when the speed is non-zero in
// cruise mode, again for the period; run on and off in cruise mode with non-zero
// speed also run the shared divider for the period.
// A new word is taken while the previous result waits on the output.
// Configuration writes are taken at any time and should come while idle.
// Depends on edsp_pkg, edsp_ctrl, edsp_dp and edsp_div.
`default_nettype none

module encoder_driven_stepper_pulser (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Input words
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata, lowest bit up: pin_a, pin_b, position_value[15:0], zero fill
    input  wire logic [edsp_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // tuser: opcode[2:0]
    input  wire logic [edsp_pkg::IN_TUSER_W-1:0] s_axis_tuser,
    // Result words
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // tdata, lowest bit up: step_pulse, step_dir, position[15:0], speed[14:0],
    // step_period[19:0], running, zero fill
    output logic [edsp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // Configuration writes
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [edsp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [edsp_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    edsp_pkg::t_cmd    w_cmd;
    edsp_pkg::t_status w_status;

    // Register writes are always accepted
    assign o_cfg_ready = 1'b1;

    edsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    edsp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule

`default_nettype wire
